// ----- rtl/core/dtoi_pkg.sv -----
`timescale 1ns / 1ps

package dtoi_pkg;

	localparam int unsigned CHAR_LIMIT_DEFAULT = 65535;
	localparam int unsigned CHAR_W = 8;
	localparam int unsigned VALUE_W = 64;
	localparam int unsigned COUNT_W = 16;

	localparam logic [CHAR_W-1:0] CH_MINUS = 8'h2D;
	localparam logic [CHAR_W-1:0] CH_ZERO = 8'h30;
	localparam logic [CHAR_W-1:0] CH_NINE = 8'h39;

	// largest magnitude that can still take another digit, floor(int64 max / 10)
	localparam logic signed [VALUE_W-1:0] ACC_THRESH = 64'sd922337203685477580;
	// last digit allowed at the threshold, for positive and negative values
	localparam logic [3:0] LAST_DIGIT_POS = 4'd7;
	localparam logic [3:0] LAST_DIGIT_NEG = 4'd8;

	typedef enum logic [1:0] {
		ST_OK        = 2'd0,
		ST_NO_DIGITS = 2'd1,
		ST_OVERFLOW  = 2'd2
	} status_t;

	typedef struct packed {
		status_t                    status;
		logic signed [VALUE_W-1:0]  value;
		logic [COUNT_W-1:0]         consumed;
	} result_t;

endpackage

// ----- rtl/core/decimal_text_to_int64.sv -----
`timescale 1ns / 1ps

// Streaming decimal text to int64 parser. Characters of a buffer enter one
// per transfer on the slave side, the final character of the buffer marked
// with s_tlast. A leading '-' makes the value negative; digits are then
// accumulated with an overflow check against the int64 range. Parsing ends
// at the first non-digit, on overflow, or at the marked last character, and
// then exactly one result transfer leaves on the master side: status ok with
// the signed value and the number of characters consumed (sign included),
// no digits, or overflow (value and count zero unless ok). Characters of the
// same buffer that follow a result are dropped without output. The block
// takes one character per clock cycle: a character sits in the input
// register while the parse step updates the accumulator and, when the
// character closes the parse, writes the result register; the result is
// offered on the master side from that result register, which follows the
// input register. Throughput drops below one per cycle only while a result
// waits in the output register and the character in the input register
// would produce another one.
module decimal_text_to_int64 #(
	parameter int unsigned CHAR_LIMIT = dtoi_pkg::CHAR_LIMIT_DEFAULT
) (
	input  logic        clk,
	input  logic        arst_n,
	// character stream
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [7:0]  s_tdata,   // [7:0] char_code
	input  logic        s_tlast,   // last_of_buffer
	// result stream
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [79:0] m_tdata,   // [63:0] value, [79:64] consumed
	output logic [1:0]  m_tuser    // [1:0] status
);

	// input register
	logic                          s1_valid_q;
	logic [dtoi_pkg::CHAR_W-1:0]   char_s1;
	logic                          last_s1;

	// parse step
	logic                          fire;
	logic                          res_valid;
	dtoi_pkg::result_t             res;

	// result register
	logic                          out_valid_q;
	dtoi_pkg::result_t             out_q;
	logic                          out_free;

	// the result register can take a new result when empty or being drained
	assign out_free = !out_valid_q || m_tready;
	// a character without a result never waits on the output side
	assign fire     = s1_valid_q && (!res_valid || out_free);
	assign s_tready = !s1_valid_q || fire;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s1_valid_q <= 1'b0;
		end else if (s_tready) begin
			s1_valid_q <= s_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_tvalid && s_tready) begin
			char_s1 <= s_tdata[dtoi_pkg::CHAR_W-1:0];
			last_s1 <= s_tlast;
		end
	end

	dtoi_parse #(
		.CHAR_LIMIT(CHAR_LIMIT)
	) u_parse (
		.clk       (clk),
		.arst_n    (arst_n),
		.fire      (fire),
		.char_code (char_s1),
		.last      (last_s1),
		.res_valid (res_valid),
		.res       (res)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (fire && res_valid) begin
			out_valid_q <= 1'b1;
		end else if (m_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (fire && res_valid) begin
			out_q <= res;
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = {out_q.consumed, out_q.value};
	assign m_tuser  = out_q.status;

	// a new result is never written over one that is still waiting
	assert property (@(posedge clk) disable iff (!arst_n)
		(fire && res_valid) |-> out_free)
		else $error("result register overwritten while stalled");

	// stalling the input side only happens with a character held in the input register
	assert property (@(posedge clk) disable iff (!arst_n)
		!s_tready |-> (s1_valid_q && res_valid && !out_free))
		else $error("input side stalled without cause");

	// an ok result always counts at least one character
	assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid && (out_q.status == dtoi_pkg::ST_OK)) |-> (out_q.consumed != '0))
		else $error("ok result with zero consumed count");

	// failed parses carry zero value and count
	assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid && (out_q.status != dtoi_pkg::ST_OK)) |->
			((out_q.value == '0) && (out_q.consumed == '0)))
		else $error("failed parse with nonzero payload");

endmodule

// ----- rtl/core/dtoi_parse.sv -----
`timescale 1ns / 1ps

// per-character parse step and parser state
module dtoi_parse #(
	parameter int unsigned CHAR_LIMIT = dtoi_pkg::CHAR_LIMIT_DEFAULT
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           fire,
	input  logic [dtoi_pkg::CHAR_W-1:0]    char_code,
	input  logic                           last,
	output logic                           res_valid,
	output dtoi_pkg::result_t              res
);

	localparam int unsigned CNT_W = dtoi_pkg::COUNT_W;
	localparam logic [CNT_W-1:0] POS_LIMIT =
		CNT_W'((CHAR_LIMIT < 2) ? 2 : CHAR_LIMIT);

	// signed accumulator: digits are subtracted once a minus was seen
	logic signed [dtoi_pkg::VALUE_W-1:0] acc_q, acc_d;
	logic                                neg_q, neg_d;
	logic [dtoi_pkg::COUNT_W-1:0]        pos_q, pos_d;
	logic                                skip_q, skip_d;

	logic [dtoi_pkg::CHAR_W-1:0]          digit_full;
	logic [3:0]                           digit;
	logic                                 is_digit;
	logic                                 is_minus;
	logic                                 ovf;
	logic [3:0]                           last_digit;
	logic [dtoi_pkg::COUNT_W-1:0]         pos_bump;
	logic signed [dtoi_pkg::VALUE_W-1:0]  acc_x10;
	logic signed [dtoi_pkg::VALUE_W-1:0]  acc_digit;
	logic signed [dtoi_pkg::VALUE_W-1:0]  digit_ext;

	assign digit_full = char_code - dtoi_pkg::CH_ZERO;
	assign digit      = digit_full[3:0];
	assign digit_ext  = {{(dtoi_pkg::VALUE_W-4){1'b0}}, digit};
	assign is_minus   = (pos_q == '0) && (char_code == dtoi_pkg::CH_MINUS);
	assign pos_bump   = (pos_q < POS_LIMIT) ? pos_q + 1'b1 : pos_q;
	assign last_digit = neg_q ? dtoi_pkg::LAST_DIGIT_NEG : dtoi_pkg::LAST_DIGIT_POS;

	always_comb begin
		is_digit = char_code inside {[dtoi_pkg::CH_ZERO:dtoi_pkg::CH_NINE]};
	end

	// overflow test on the magnitude, mirrored for negative values
	always_comb begin
		if (neg_q) begin
			ovf = (acc_q < -dtoi_pkg::ACC_THRESH) ||
				((acc_q == -dtoi_pkg::ACC_THRESH) && (digit > last_digit));
		end else begin
			ovf = (acc_q > dtoi_pkg::ACC_THRESH) ||
				((acc_q == dtoi_pkg::ACC_THRESH) && (digit > last_digit));
		end
	end

	assign acc_x10   = (acc_q <<< 3) + (acc_q <<< 1);
	assign acc_digit = neg_q ? acc_x10 - digit_ext : acc_x10 + digit_ext;

	// next state and result
	always_comb begin
		acc_d     = acc_q;
		neg_d     = neg_q;
		pos_d     = pos_q;
		skip_d    = skip_q;
		res_valid = 1'b0;
		res       = '{status: dtoi_pkg::ST_NO_DIGITS, value: '0, consumed: '0};
		if (skip_q) begin
			if (last) begin
				skip_d = 1'b0;
			end
		end else if (is_minus) begin
			neg_d = 1'b1;
			pos_d = pos_bump;
			if (last) begin
				// sign alone
				res_valid = 1'b1;
				acc_d     = '0;
				neg_d     = 1'b0;
				pos_d     = '0;
			end
		end else if (!is_digit) begin
			// terminating character, not consumed
			res_valid = 1'b1;
			if (pos_q > {{(dtoi_pkg::COUNT_W-1){1'b0}}, neg_q}) begin
				res = '{status: dtoi_pkg::ST_OK, value: acc_q, consumed: pos_q};
			end
			acc_d  = '0;
			neg_d  = 1'b0;
			pos_d  = '0;
			skip_d = !last;
		end else if (ovf) begin
			res_valid  = 1'b1;
			res.status = dtoi_pkg::ST_OVERFLOW;
			acc_d      = '0;
			neg_d      = 1'b0;
			pos_d      = '0;
			skip_d     = !last;
		end else begin
			acc_d = acc_digit;
			pos_d = pos_bump;
			if (last) begin
				res_valid = 1'b1;
				res = '{status: dtoi_pkg::ST_OK, value: acc_digit, consumed: pos_bump};
				acc_d = '0;
				neg_d = 1'b0;
				pos_d = '0;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			acc_q  <= '0;
			neg_q  <= 1'b0;
			pos_q  <= '0;
			skip_q <= 1'b0;
		end else if (fire) begin
			acc_q  <= acc_d;
			neg_q  <= neg_d;
			pos_q  <= pos_d;
			skip_q <= skip_d;
		end
	end

endmodule

// ----- tb/tb_top.sv -----
`timescale 1ns / 1ps

module tb_top;

	localparam int unsigned CYCLE_LIMIT = 1_000_000;
	localparam int unsigned ITEMS_PER_PHASE = 270;
	localparam int unsigned HOLD_CYCLES = 300;
	localparam int unsigned COUNT_SAT = (dtoi_pkg::CHAR_LIMIT_DEFAULT < 2) ? 2 :
		dtoi_pkg::CHAR_LIMIT_DEFAULT;
	localparam logic [63:0] INT64_MAX_MAG = 64'h7FFF_FFFF_FFFF_FFFF;

	typedef struct {
		logic [7:0] code;
		logic       last;
	} text_char_t;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        s_tvalid = 1'b0;
	logic        s_tready;
	logic [7:0]  s_tdata = 8'h00;
	logic        s_tlast = 1'b0;
	logic        m_tvalid;
	logic        m_tready = 1'b0;
	logic [79:0] m_tdata;
	logic [1:0]  m_tuser;

	text_char_t          pending_chars[$];
	dtoi_pkg::result_t   pending_results[$];
	text_char_t          head_char;
	dtoi_pkg::result_t   want;

	// parser state mirrored by the predictor
	logic [63:0] text_magnitude = '0;
	bit          minus_seen = 1'b0;
	logic [15:0] char_count = '0;
	bit          drop_rest = 1'b0;

	int unsigned sender_idle_pct = 0;
	int unsigned recv_stall_pct = 0;
	int unsigned mismatches = 0;
	int unsigned counted_items = 0;
	int unsigned watch_cycles = 0;
	bit          char_taken = 1'b0;
	bit          start_pressure = 1'b0;
	bit          stall_hold = 1'b0;

	always #6 clk = ~clk;

	decimal_text_to_int64 u_top (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tlast  (s_tlast),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tuser  (m_tuser)
	);

	task automatic report_mismatch(input string msg);
		mismatches++;
		if (mismatches <= 100) begin
			$display("MISMATCH at %0t: %s", $time, msg);
		end
	endtask

	function automatic void emit_result(input dtoi_pkg::status_t st, input logic [63:0] val,
			input logic [15:0] cnt, input logic last);
		dtoi_pkg::result_t r;
		r.status = st;
		r.value = val;
		r.consumed = cnt;
		pending_results.push_back(r);
		text_magnitude = '0;
		minus_seen = 1'b0;
		char_count = '0;
		drop_rest = !last;
	endfunction

	function automatic void close_number(input logic last);
		if (char_count > (minus_seen ? 16'd1 : 16'd0)) begin
			emit_result(dtoi_pkg::ST_OK, minus_seen ? -text_magnitude : text_magnitude,
				char_count, last);
		end else begin
			emit_result(dtoi_pkg::ST_NO_DIGITS, '0, '0, last);
		end
	endfunction

	function automatic void bump_count();
		if (char_count < COUNT_SAT) begin
			char_count++;
		end
	endfunction

	// one accepted character through the parser
	function automatic void parse_char(input logic [7:0] code, input logic last);
		logic [63:0] ceiling;
		logic [63:0] digit;
		if (drop_rest) begin
			if (last) begin
				drop_rest = 1'b0;
			end
			return;
		end
		if (char_count == 0 && code == dtoi_pkg::CH_MINUS) begin
			minus_seen = 1'b1;
			bump_count();
			if (last) begin
				close_number(1'b1);
			end
			return;
		end
		if (code < dtoi_pkg::CH_ZERO || code > dtoi_pkg::CH_NINE) begin
			close_number(last);
			return;
		end
		digit = 64'(code - dtoi_pkg::CH_ZERO);
		ceiling = INT64_MAX_MAG + (minus_seen ? 64'd1 : 64'd0);
		if (text_magnitude > (ceiling - digit) / 64'd10) begin
			emit_result(dtoi_pkg::ST_OVERFLOW, '0, '0, last);
			return;
		end
		text_magnitude = text_magnitude * 64'd10 + digit;
		bump_count();
		if (last) begin
			close_number(1'b1);
		end
	endfunction

	task automatic push_char(input logic [7:0] code, input logic last, input bit counts);
		text_char_t c;
		c.code = code;
		c.last = last;
		pending_chars.push_back(c);
		if (counts) begin
			counted_items++;
		end
	endtask

	task automatic push_text(input string txt);
		for (int i = 0; i < txt.len(); i++) begin
			push_char(txt[i], i == txt.len() - 1, 1'b1);
		end
	endtask

	task automatic push_digits(input int unsigned n, input bit nonzero_first, input bit last_on_end);
		for (int unsigned i = 0; i < n; i++) begin
			push_char(dtoi_pkg::CH_ZERO + 8'((i == 0 && nonzero_first) ? $urandom_range(1, 9) :
				$urandom_range(9)), last_on_end && i == n - 1, 1'b1);
		end
	endtask

	// one random buffer, mostly well formed numbers
	task automatic push_random_buffer();
		int unsigned kind;
		int unsigned n;
		int unsigned tail;
		int unsigned junk;
		logic [7:0]  c;
		string       prefix;
		kind = $urandom_range(99);
		if (kind < 45) begin
			if ($urandom_range(1)) begin
				push_char(dtoi_pkg::CH_MINUS, 1'b0, 1'b1);
			end
			n = ($urandom_range(9) == 0) ? $urandom_range(15, 21) : $urandom_range(1, 8);
			tail = $urandom_range(2);
			push_digits(n, 1'b0, tail == 0);
			if (tail != 0) begin
				// terminator, then up to three bytes that get dropped
				do begin
					c = 8'($urandom_range(255));
				end while (c >= dtoi_pkg::CH_ZERO && c <= dtoi_pkg::CH_NINE);
				junk = $urandom_range(3);
				push_char(c, junk == 0, 1'b1);
				for (int unsigned i = 0; i < junk; i++) begin
					push_char(8'($urandom_range(255)), i == junk - 1, 1'b1);
				end
			end
		end else if (kind < 65) begin
			// around the int64 limits, with and without sign and leading zeros
			if ($urandom_range(1)) begin
				push_char(dtoi_pkg::CH_MINUS, 1'b0, 1'b1);
			end
			n = $urandom_range(2);
			for (int unsigned i = 0; i < n; i++) begin
				push_char(dtoi_pkg::CH_ZERO, 1'b0, 1'b1);
			end
			prefix = "92233720368547758";
			for (int i = 0; i < prefix.len(); i++) begin
				push_char(prefix[i], 1'b0, 1'b1);
			end
			push_char(dtoi_pkg::CH_ZERO + 8'($urandom_range(2)), 1'b0, 1'b1);
			tail = $urandom_range(3);
			push_char(dtoi_pkg::CH_ZERO +
				8'(($urandom_range(1)) ? $urandom_range(6, 9) : $urandom_range(9)),
				tail != 0, 1'b1);
			if (tail == 0) begin
				push_digits(1, 1'b0, 1'b1);
			end
		end else if (kind < 80) begin
			if ($urandom_range(1)) begin
				push_char(dtoi_pkg::CH_MINUS, 1'b0, 1'b1);
			end
			push_digits($urandom_range(19, 22), 1'b1, 1'b1);
		end else begin
			n = $urandom_range(1, 4);
			for (int unsigned i = 0; i < n; i++) begin
				push_char(8'($urandom_range(255)), i == n - 1, 1'b1);
			end
		end
	endtask

	task automatic wait_sent();
		while (pending_chars.size() != 0 || s_tvalid) begin
			@(posedge clk);
		end
	endtask

	// character driver
	always @(negedge clk) begin
		if (arst_n) begin
			if (!s_tvalid || char_taken) begin
				if (pending_chars.size() != 0 && $urandom_range(99) >= sender_idle_pct) begin
					head_char = pending_chars.pop_front();
					s_tvalid <= 1'b1;
					s_tdata <= head_char.code;
					s_tlast <= head_char.last;
				end else begin
					s_tvalid <= 1'b0;
				end
			end
		end
	end

	// result receiver
	always @(negedge clk) begin
		if (arst_n) begin
			m_tready <= !(stall_hold || $urandom_range(99) < recv_stall_pct);
		end
	end

	// monitor: check result transfers, then predict from character transfers
	always @(posedge clk) begin
		if (arst_n) begin
			if (m_tvalid && m_tready) begin
				if (pending_results.size() == 0) begin
					report_mismatch($sformatf("unexpected result status %0d value %0d consumed %0d",
						m_tuser, $signed(m_tdata[63:0]), m_tdata[79:64]));
				end else begin
					want = pending_results.pop_front();
					if (m_tuser !== want.status || m_tdata[63:0] !== want.value ||
							m_tdata[79:64] !== want.consumed) begin
						report_mismatch($sformatf(
							"got status %0d value %0d consumed %0d, want %0d %0d %0d",
							m_tuser, $signed(m_tdata[63:0]), m_tdata[79:64],
							want.status, want.value, want.consumed));
					end
				end
			end
			char_taken = s_tvalid && s_tready;
			if (char_taken) begin
				parse_char(s_tdata, s_tlast);
			end
		end
	end

	// long receiver hold-off so the block backs up into its input
	initial begin
		wait (start_pressure);
		@(posedge clk);
		stall_hold = 1'b1;
		repeat (HOLD_CYCLES) @(posedge clk);
		stall_hold = 1'b0;
	end

	initial begin
		while (watch_cycles < CYCLE_LIMIT) begin
			@(posedge clk);
			watch_cycles++;
		end
		$display("** decimal_text_to_int64: FAILED **");
		$finish;
	end

	initial begin
		repeat (2) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// directed: single digit, sign alone, no digits, terminator with skipped
		// rest, minus not first, byte extremes, bytes just outside the digits
		push_text("0");
		push_text("-");
		push_text("-5");
		push_text("12a3");
		push_text("--1");
		push_char(8'hFF, 1'b1, 1'b1);
		push_char(8'h00, 1'b1, 1'b1);
		push_text("4-");
		push_text("/");
		push_text(":");
		push_text("x7");
		wait_sent();

		for (int ph = 0; ph < 4; ph++) begin
			case (ph)
				0: begin
					sender_idle_pct = 0;
					recv_stall_pct = 0;
				end
				1: begin
					sender_idle_pct = 66;
					recv_stall_pct = 0;
				end
				2: begin
					sender_idle_pct = 0;
					recv_stall_pct = 66;
					start_pressure = 1'b1;
					for (int i = 0; i < 24; i++) begin
						push_digits(1, 1'b0, 1'b1);
					end
				end
				default: begin
					sender_idle_pct = 21;
					recv_stall_pct = 21;
				end
			endcase
			counted_items = 0;
			while (counted_items < ITEMS_PER_PHASE) begin
				push_random_buffer();
			end
			wait_sent();
		end

		while (pending_results.size() != 0) begin
			@(posedge clk);
		end
		repeat (10) @(posedge clk);
		if (mismatches == 0) begin
			$display("** decimal_text_to_int64: PASSED **");
		end else begin
			$display("** decimal_text_to_int64: FAILED **");
		end
		$finish;
	end

endmodule
